@@ rtl/cpu8080_subset_step_assert.svh @@
// Assertion macros shared by the RTL files
`ifndef CPU8080_SUBSET_STEP_ASSERT_SVH
`define CPU8080_SUBSET_STEP_ASSERT_SVH
// Implication checked on every edge outside reset
`define CPU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication checked in the cycle after the antecedent
`define CPU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/cpu_pkg.sv @@
`default_nettype none
package cpu_pkg;
  localparam logic [15:0] SP_RESET = 16'h0FFF;
  localparam logic [7:0] OP_HLT = 8'b01110110;
  localparam logic [7:0] MASK_SINGLE = 8'b11000111;
  localparam logic [7:0] MASK_CARRYOP = 8'b11110111;
  localparam logic [7:0] MASK_STLD = 8'b11100111;
  localparam logic [7:0] MASK_PAIR = 8'b11001111;
  localparam logic [2:0] RC_M = 3'd6;
  localparam logic [2:0] RC_A = 3'd7;

  // request kind carried in the opcode field
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE, ST_OPRD, ST_DEC, ST_OP1, ST_OP2, ST_MRD, ST_EXEC, ST_WR, ST_OUT
  } state_t;

  // memory address source
  typedef enum logic [2:0] {
    AS_LOAD, AS_PC, AS_PC1, AS_PC2, AS_HL, AS_BC, AS_DE
  } asel_t;

  // decoded instruction class
  typedef enum logic [3:0] {
    IC_NOP, IC_CARRY, IC_INCDEC, IC_CMA, IC_MOV, IC_STAX, IC_LDAX,
    IC_ADD, IC_LXI, IC_MVI
  } iclass_t;

  typedef struct packed {
    logic    mem_rd;
    logic    mem_wr;
    logic    wr_load;
    asel_t   asel;
    logic    lat_op;
    logic    lat_b1;
    logic    lat_b2;
    logic    lat_m;
    logic    exec;
  } cmd_t;

  typedef struct packed {
    iclass_t   cls;
    logic      src_m;
    logic      dst_m;
  } stat_t;

  function automatic logic parity_even(input logic [7:0] v);
    return ~(^v);
  endfunction
endpackage
`default_nettype wire

@@ rtl/cpu_if.sv @@
`default_nettype none
interface cpu_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] load_address;
  logic [7:0]  load_data;
  modport source (output valid, opcode, load_address, load_data, input ready);
  modport sink (input valid, opcode, load_address, load_data, output ready);
endinterface

interface cpu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pc;
  logic [15:0] sp;
  logic [7:0]  acc;
  logic [7:0]  reg_b;
  logic [7:0]  reg_c;
  logic [7:0]  reg_d;
  logic [7:0]  reg_e;
  logic [7:0]  reg_h;
  logic [7:0]  reg_l;
  logic [3:0]  flags;
  modport source (output valid, pc, sp, acc, reg_b, reg_c, reg_d, reg_e, reg_h, reg_l,
                  flags, input ready);
  modport sink (input valid, pc, sp, acc, reg_b, reg_c, reg_d, reg_e, reg_h, reg_l,
                flags, output ready);
endinterface
`default_nettype wire

@@ rtl/cpu8080_subset_step.sv @@
// A load writes its byte to program memory and then presents the result; a step
// makes one memory read per fetched byte through the single-port program memory.
// Throughput: one request at a time, taken the cycle after the result is
// taken, so a stalled output holds off the next request.
// Reset (rst_n low, synchronous): PC 0, SP 0x0FFF, registers and flags 0.
// Program memory is not cleared; unwritten bytes read undefined.
`default_nettype none
module cpu8080_subset_step #(
  parameter int ADDR_BITS = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  cpu_in_if.sink   in_ch,
  cpu_out_if.source out_ch
);
  import cpu_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cpu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_opcode (in_ch.opcode),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cpu_dp #(.ADDR_BITS(ADDR_BITS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_load_address (in_ch.load_address),
    .in_load_data    (in_ch.load_data),
    .pc              (out_ch.pc),
    .sp              (out_ch.sp),
    .acc             (out_ch.acc),
    .reg_b           (out_ch.reg_b),
    .reg_c           (out_ch.reg_c),
    .reg_d           (out_ch.reg_d),
    .reg_e           (out_ch.reg_e),
    .reg_h           (out_ch.reg_h),
    .reg_l           (out_ch.reg_l),
    .flags           (out_ch.flags)
  );
endmodule
`default_nettype wire

@@ rtl/cpu_ctrl.sv @@
`default_nettype none
module cpu_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           in_opcode,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire cpu_pkg::stat_t stat,
  output cpu_pkg::cmd_t       cmd
);
  import cpu_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.asel  = AS_PC;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (kind_t'(in_opcode) == KIND_LOAD) begin
            cmd.mem_wr  = 1'b1;
            cmd.wr_load = 1'b1;
            cmd.asel    = AS_LOAD;
            state_nxt   = ST_OUT;
          end else begin
            cmd.mem_rd = 1'b1;
            state_nxt  = ST_OPRD;
          end
        end
      end
      ST_OPRD: begin
        cmd.lat_op = 1'b1;
        state_nxt  = ST_DEC;
      end
      ST_DEC: begin
        // issue the next read the class needs
        case (stat.cls)
          IC_LXI, IC_MVI: begin
            cmd.mem_rd = 1'b1;
            cmd.asel   = AS_PC1;
            state_nxt  = ST_OP1;
          end
          IC_LDAX: begin
            cmd.mem_rd = 1'b1;
            cmd.asel   = stat.dst_m ? AS_DE : AS_BC;
            state_nxt  = ST_MRD;
          end
          default: begin
            if (stat.src_m) begin
              cmd.mem_rd = 1'b1;
              cmd.asel   = AS_HL;
              state_nxt  = ST_MRD;
            end else begin
              state_nxt = ST_EXEC;
            end
          end
        endcase
      end
      ST_OP1: begin
        cmd.lat_b1 = 1'b1;
        if (stat.cls == IC_LXI) begin
          cmd.mem_rd = 1'b1;
          cmd.asel   = AS_PC2;
          state_nxt  = ST_OP2;
        end else begin
          state_nxt = ST_EXEC;
        end
      end
      ST_OP2: begin
        cmd.lat_b2 = 1'b1;
        state_nxt  = ST_EXEC;
      end
      ST_MRD: begin
        cmd.lat_m = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        // memory write of the result, or of A for STAX, where the destination is memory;
        // for LDAX dst_m only selects the pair, nothing is written
        if (stat.cls == IC_STAX) begin
          cmd.mem_wr = 1'b1;
          cmd.asel   = stat.dst_m ? AS_DE : AS_BC;
        end else if (stat.dst_m && stat.cls != IC_LDAX) begin
          cmd.mem_wr = 1'b1;
          cmd.asel   = AS_HL;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `include "cpu8080_subset_step_assert.svh"
  `CPU_ASSERT_IMP(a_ready_idle, in_ready, !out_valid)
  `CPU_ASSERT_NXT(a_exec_wr, cmd.exec, state_r == ST_WR)
  `CPU_ASSERT_IMP(a_rw_excl, cmd.mem_rd, !cmd.mem_wr)
endmodule
`default_nettype wire

@@ rtl/cpu_dp.sv @@
`default_nettype none
module cpu_dp #(
  parameter int ADDR_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire cpu_pkg::cmd_t  cmd,
  output cpu_pkg::stat_t      stat,
  input  wire logic [15:0]    in_load_address,
  input  wire logic [7:0]     in_load_data,
  output logic [15:0]         pc,
  output logic [15:0]         sp,
  output logic [7:0]          acc,
  output logic [7:0]          reg_b,
  output logic [7:0]          reg_c,
  output logic [7:0]          reg_d,
  output logic [7:0]          reg_e,
  output logic [7:0]          reg_h,
  output logic [7:0]          reg_l,
  output logic [3:0]          flags
);
  import cpu_pkg::*;

  logic [7:0]  mem_r [0:(1 << ADDR_BITS) - 1];
  logic [7:0]  rdata_r;
  logic [ADDR_BITS-1:0] addr;
  logic [7:0]  wdata;
  logic [7:0]  op_r, b1_r, b2_r, m_r, res_r;
  logic [15:0] pc_r, sp_r;
  logic [7:0]  a_r;
  logic [7:0]  gr_r [0:5];
  logic        cy_r, z_r, s_r, p_r;
  logic [2:0]  dcode, scode;
  logic [7:0]  sval, dval, newv;
  logic [8:0]  sum;
  logic [1:0]  adv;
  logic [1:0]  pair;
  logic        chg_zsp;

  assign dcode = op_r[5:3];
  assign scode = op_r[2:0];
  assign pair  = op_r[5:4];

  // decode
  always_comb begin
    stat = '0;
    stat.cls = IC_NOP;
    if ((op_r & MASK_CARRYOP) == 8'h37) stat.cls = IC_CARRY;
    else if ((op_r & MASK_SINGLE) == 8'h04 || (op_r & MASK_SINGLE) == 8'h05) begin
      stat.cls = IC_INCDEC;
      stat.src_m = (dcode == RC_M);
      stat.dst_m = (dcode == RC_M);
    end else if (op_r == 8'h2F) stat.cls = IC_CMA;
    else if (op_r[7:6] == 2'b01 && op_r != OP_HLT) begin
      stat.cls = IC_MOV;
      stat.src_m = (scode == RC_M);
      stat.dst_m = (dcode == RC_M);
    end else if ((op_r & MASK_STLD) == 8'h02) begin
      stat.cls   = op_r[3] ? IC_LDAX : IC_STAX;
      stat.dst_m = op_r[4];
    end else if (op_r[7:6] == 2'b10 && op_r[5:4] == 2'b00) begin
      stat.cls   = IC_ADD;
      stat.src_m = (scode == RC_M);
    end else if ((op_r & MASK_PAIR) == 8'h01) stat.cls = IC_LXI;
    else if ((op_r & MASK_SINGLE) == 8'h06) begin
      stat.cls   = IC_MVI;
      stat.dst_m = (dcode == RC_M);
    end
  end

  // address select
  always_comb begin
    case (cmd.asel)
      AS_LOAD: addr = in_load_address[ADDR_BITS-1:0];
      AS_PC:   addr = pc_r[ADDR_BITS-1:0];
      AS_PC1:  addr = ADDR_BITS'(pc_r + 16'd1);
      AS_PC2:  addr = ADDR_BITS'(pc_r + 16'd2);
      AS_HL:   addr = ADDR_BITS'({gr_r[4], gr_r[5]});
      AS_BC:   addr = ADDR_BITS'({gr_r[0], gr_r[1]});
      AS_DE:   addr = ADDR_BITS'({gr_r[2], gr_r[3]});
      default: addr = pc_r[ADDR_BITS-1:0];
    endcase
    wdata = cmd.wr_load ? in_load_data : (stat.cls == IC_STAX ? a_r : res_r);
  end

  // program memory, single port
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem_r[addr] <= wdata;
    if (cmd.mem_rd) rdata_r <= mem_r[addr];
  end

  // latches for fetched bytes
  always_ff @(posedge clk) begin
    if (cmd.lat_op) op_r <= rdata_r;
    if (cmd.lat_b1) b1_r <= rdata_r;
    if (cmd.lat_b2) b2_r <= rdata_r;
    if (cmd.lat_m)  m_r  <= rdata_r;
  end

  // operand selection and ALU
  always_comb begin
    case (scode)
      RC_M:    sval = m_r;
      RC_A:    sval = a_r;
      default: sval = gr_r[scode];
    endcase
    case (dcode)
      RC_M:    dval = m_r;
      RC_A:    dval = a_r;
      default: dval = gr_r[dcode];
    endcase
    sum = {1'b0, a_r} + {1'b0, sval} + {8'd0, op_r[3] & cy_r};
    newv = 8'd0;
    chg_zsp = 1'b0;
    adv = 2'd1;
    case (stat.cls)
      IC_INCDEC: begin
        newv = op_r[0] ? dval - 8'd1 : dval + 8'd1;
        chg_zsp = 1'b1;
      end
      IC_MOV:  newv = sval;
      IC_ADD: begin
        newv = sum[7:0];
        chg_zsp = 1'b1;
      end
      IC_MVI: begin
        newv = b1_r;
        adv = 2'd2;
      end
      IC_LDAX: newv = m_r;
      IC_CMA:  newv = ~a_r;
      IC_LXI:  adv = 2'd3;
      default: newv = 8'd0;
    endcase
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
      sp_r <= SP_RESET;
      a_r  <= '0;
      for (int i = 0; i < 6; i++) gr_r[i] <= '0;
      cy_r <= 1'b0;
      z_r  <= 1'b0;
      s_r  <= 1'b0;
      p_r  <= 1'b0;
    end else if (cmd.exec) begin
      pc_r  <= pc_r + {14'd0, adv};
      res_r <= newv;
      if (chg_zsp) begin
        z_r <= (newv == 8'd0);
        s_r <= newv[7];
        p_r <= parity_even(newv);
      end
      case (stat.cls)
        IC_CARRY: cy_r <= op_r[3] ? ~cy_r : 1'b1;
        IC_ADD: begin
          cy_r <= sum[8];
          a_r  <= newv;
        end
        IC_CMA, IC_LDAX: a_r <= newv;
        IC_INCDEC, IC_MOV, IC_MVI: begin
          if (dcode == RC_A) a_r <= newv;
          else if (dcode != RC_M) gr_r[dcode] <= newv;
        end
        IC_LXI: begin
          if (pair == 2'd3) sp_r <= {b2_r, b1_r};
          else begin
            gr_r[{pair, 1'b0}] <= b2_r;
            gr_r[{pair, 1'b1}] <= b1_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign pc = pc_r;
  assign sp = sp_r;
  assign acc = a_r;
  assign reg_b = gr_r[0];
  assign reg_c = gr_r[1];
  assign reg_d = gr_r[2];
  assign reg_e = gr_r[3];
  assign reg_h = gr_r[4];
  assign reg_l = gr_r[5];
  assign flags = {s_r, z_r, p_r, cy_r};

  `include "cpu8080_subset_step_assert.svh"
  `CPU_ASSERT_NXT(a_pc_hold, !cmd.exec, pc_r == $past(pc_r))
  `CPU_ASSERT_NXT(a_sp_lxi, cmd.exec && stat.cls != IC_LXI, sp_r == $past(sp_r))
  `CPU_ASSERT_NXT(a_cy_hold, cmd.exec && stat.cls == IC_MOV, cy_r == $past(cy_r))
endmodule
`default_nettype wire
